>>> src/lim_pkg.sv
// Shared types and constants for the list intersection matcher.
// No dependencies; every other file refers to it by scoped names.
package lim_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 2;

   // Operation codes of a request transfer
   localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic append_first;
      logic append_second;
      logic scan_start;
      logic scan;
      logic finish;
   } lim_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic list_empty;
      logic scan_last;
      logic stall;
      logic out_free;
   } lim_sts_type;

endpackage

>>> src/lim_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on lim_pkg for the field widths.
interface lim_req_if;
   logic                                valid;
   logic                                ready;
   logic        [lim_pkg::OP_W-1:0]     operation;
   logic signed [lim_pkg::DATA_W-1:0]   element_value;

   modport source (output valid, output operation, output element_value, input ready);
   modport sink   (input valid, input operation, input element_value, output ready);
endinterface

interface lim_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lim_pkg::DATA_W-1:0]   match_value;
   logic                                last_match;
   logic                                no_match;
   logic                                overflow;

   modport source (output valid, output match_value, output last_match,
                   output no_match, output overflow, input ready);
   modport sink   (input valid, input match_value, input last_match,
                   input no_match, input overflow, output ready);
endinterface

>>> src/lim_dp.sv
// Datapath: both list stores, their counts, the pair scan counters, the
// pending-match register and the response output register. Uses lim_pkg.
module lim_dp #(
   parameter int DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lim_pkg::lim_cmd_type               cmd,
   output lim_pkg::lim_sts_type               sts,
   input  logic signed [lim_pkg::DATA_W-1:0]  req_element_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [lim_pkg::DATA_W-1:0]  rsp_match_value,
   output logic                               rsp_last_match,
   output logic                               rsp_no_match,
   output logic                               rsp_overflow
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

   logic signed [lim_pkg::DATA_W-1:0] first_store_ff  [DEPTH];
   logic signed [lim_pkg::DATA_W-1:0] second_store_ff [DEPTH];

   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic             pend_valid_ff, pend_valid_in;
   logic signed [lim_pkg::DATA_W-1:0] pend_value_ff, pend_value_in;
   logic             out_valid_ff, out_valid_in;
   logic signed [lim_pkg::DATA_W-1:0] out_value_ff, out_value_in;
   logic             out_last_ff, out_last_in;
   logic             out_empty_ff, out_empty_in;
   logic             out_ovf_ff, out_ovf_in;

   logic signed [lim_pkg::DATA_W-1:0] first_rd_ff;
   logic signed [lim_pkg::DATA_W-1:0] second_rd_ff;
   logic             hit;
   logic             out_free;
   logic             stall;
   logic             advance;
   logic             out_load_scan;
   logic             finish_go;
   logic             first_has_room;
   logic             second_has_room;
   logic             i_at_end;
   logic             j_at_end;

   assign hit       = (first_rd_ff == second_rd_ff);
   assign out_free  = !out_valid_ff || rsp_ready;
   // A second match cannot be parked while the output register is still held
   assign stall     = hit && pend_valid_ff && !out_free;
   assign advance   = cmd.scan && !stall;
   assign out_load_scan = advance && hit && pend_valid_ff;
   assign finish_go = cmd.finish && out_free;

   assign first_has_room  = (first_count_ff < CNT_FULL);
   assign second_has_room = (second_count_ff < CNT_FULL);
   assign i_at_end = (i_ff == IDX_W'(first_count_ff - CNT_ONE));
   assign j_at_end = (j_ff == IDX_W'(second_count_ff - CNT_ONE));

   assign sts.list_empty = (first_count_ff == '0) || (second_count_ff == '0);
   assign sts.scan_last  = i_at_end && j_at_end;
   assign sts.stall      = stall;
   assign sts.out_free   = out_free;

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      pend_valid_in   = pend_valid_ff;
      pend_value_in   = pend_value_ff;
      out_valid_in    = out_valid_ff;
      out_value_in    = out_value_ff;
      out_last_in     = out_last_ff;
      out_empty_in    = out_empty_ff;
      out_ovf_in      = out_ovf_ff;

      if (cmd.append_first) begin
         if (first_has_room) begin
            first_count_in = first_count_ff + CNT_ONE;
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.append_second) begin
         if (second_has_room) begin
            second_count_in = second_count_ff + CNT_ONE;
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (cmd.scan_start) begin
         i_in          = '0;
         j_in          = '0;
         pend_valid_in = 1'b0;
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         if (j_at_end) begin
            j_in = '0;
            i_in = i_ff + IDX_ONE;
         end else begin
            j_in = j_ff + IDX_ONE;
         end
         if (hit) begin
            pend_valid_in = 1'b1;
            pend_value_in = first_rd_ff;
         end
      end

      // Push the older match out; it cannot be the last one
      if (out_load_scan) begin
         out_valid_in = 1'b1;
         out_value_in = pend_value_ff;
         out_last_in  = 1'b0;
         out_empty_in = 1'b0;
         out_ovf_in   = dropped_ff;
      end

      // Close the run with the parked match, or with the empty result
      if (finish_go) begin
         out_valid_in    = 1'b1;
         out_value_in    = pend_valid_ff ? pend_value_ff : '0;
         out_last_in     = 1'b1;
         out_empty_in    = !pend_valid_ff;
         out_ovf_in      = dropped_ff;
         pend_valid_in   = 1'b0;
         first_count_in  = '0;
         second_count_in = '0;
         dropped_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append_first && first_has_room) begin
         first_store_ff[first_count_ff[IDX_W-1:0]] <= req_element_value;
      end
      if (cmd.append_second && second_has_room) begin
         second_store_ff[second_count_ff[IDX_W-1:0]] <= req_element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         i_ff            <= '0;
         j_ff            <= '0;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         pend_valid_ff   <= pend_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      // Read at the next scan position so the data lines up with i_ff and j_ff
      first_rd_ff   <= first_store_ff[i_in];
      second_rd_ff  <= second_store_ff[j_in];
      pend_value_ff <= pend_value_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_match_value = out_value_ff;
   assign rsp_last_match  = out_last_ff;
   assign rsp_no_match    = out_empty_ff;
   assign rsp_overflow    = out_ovf_ff;

endmodule

>>> src/lim_ctrl.sv
// Controller: decodes request transfers and sequences the pair scan.
// Uses lim_pkg for operation codes and the command/status structs.
module lim_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lim_pkg::OP_W-1:0]      req_operation,
   output lim_pkg::lim_cmd_type          cmd,
   input  lim_pkg::lim_sts_type          sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  lim_pkg::OP_APPEND_FIRST: begin
                     cmd.append_first = 1'b1;
                  end
                  lim_pkg::OP_APPEND_SECOND: begin
                     cmd.append_second = 1'b1;
                  end
                  lim_pkg::OP_COMPUTE: begin
                     cmd.scan_start = 1'b1;
                     state_in = sts.list_empty ? ST_FINISH : ST_SCAN;
                  end
                  default: begin
                     // unused code: drop the transfer
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (!sts.stall && sts.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/list_intersection_matcher.sv
// Top level of the list intersection matcher: controller plus datapath.
// Depends on lim_pkg, lim_ifs, lim_ctrl and lim_dp.
//
// Two lists of up to DEPTH signed 32-bit values are filled by append
// transfers (operation 0 or 1); appends to a full list are dropped and
// reported in the overflow bit of the next run. A compute transfer
// (operation 2) walks every pair of the first list against the second,
// one compare per cycle unless the scan stalls, and returns the first-list
// value for each equal pair, in order, with last_match on the final
// response. A run with no equal pair returns one response with no_match
// set and a zero value. A compute holds the request side through a scan
// of first_count * second_count pairs (at most DEPTH*DEPTH), paced by the
// single comparator, and a closing step; the scan stalls while the response
// side holds back a waiting result and a further match is found, and the
// closing step waits for the output register to free. Responses are held
// in an output register, so appends are taken while the last response of
// a run is still waiting. Both counts clear at the end of every run.
module list_intersection_matcher #(
   parameter int DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   lim_req_if.sink    req_ch,
   lim_rsp_if.source  rsp_ch
);

   lim_pkg::lim_cmd_type cmd;
   lim_pkg::lim_sts_type sts;

   lim_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .cmd           (cmd),
      .sts           (sts)
   );

   lim_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_element_value (req_ch.element_value),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_match_value   (rsp_ch.match_value),
      .rsp_last_match    (rsp_ch.last_match),
      .rsp_no_match      (rsp_ch.no_match),
      .rsp_overflow      (rsp_ch.overflow)
   );

endmodule

>>> src/lim_checker.sv
// Port-level checks for the list intersection matcher, bound to the top level.
// Uses lim_pkg for the compute operation code.
module lim_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [lim_pkg::OP_W-1:0]           req_operation,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [lim_pkg::DATA_W-1:0]  rsp_match_value,
   input logic                               rsp_last_match,
   input logic                               rsp_no_match,
   input logic                               rsp_overflow
);

   // A held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_value)
         && $stable(rsp_last_match) && $stable(rsp_no_match) && $stable(rsp_overflow))
      else $error("response changed while held");

   // The empty result closes its run and carries a zero value
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_match |-> rsp_last_match && (rsp_match_value == '0))
      else $error("malformed empty response");

   // A compute transfer blocks further requests while the run goes on
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == lim_pkg::OP_COMPUTE) |=> !req_ready)
      else $error("request taken during a run");

   // A result that is not the last can only be waiting while its run is open
   a_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_match |-> !req_ready)
      else $error("run closed before its last response");

endmodule

bind list_intersection_matcher lim_checker u_lim_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_operation   (req_ch.operation),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_match_value (rsp_ch.match_value),
   .rsp_last_match  (rsp_ch.last_match),
   .rsp_no_match    (rsp_ch.no_match),
   .rsp_overflow    (rsp_ch.overflow)
);
